// ===== hw/rtl/signed_unsigned_integer_divider_top_macros.svh =====
// Assertion macros shared by the divider checker.
`ifndef SIGNED_UNSIGNED_INTEGER_DIVIDER_TOP_MACROS_SVH
`define SIGNED_UNSIGNED_INTEGER_DIVIDER_TOP_MACROS_SVH

// Checked at every rising edge while reset is released.
`define SUD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SUD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sud_pkg.sv =====
// Package with the types and constants of the integer divider.
`default_nettype none

package sud_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
        logic               signed_mode;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder_out;
        logic               div_by_zero;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/sud_stream_if.sv =====
// Valid/ready stream interface that carries one payload beat per handshake.
`default_nettype none

interface sud_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/signed_unsigned_integer_divider_top.sv =====
// Top level of the pipelined signed and unsigned integer divider.
//
// The request channel i_req carries a dividend, a divisor and a signed-mode
// flag; the response channel o_rsp returns quotient, remainder and a
// divide-by-zero flag, one response beat per request beat, in order.
// Signed mode divides two's complement values with truncation toward zero,
// and the remainder follows the sign of the dividend.
// The datapath is an input stage that takes magnitudes, WIDTH restoring
// stages that each settle one quotient bit, and an output stage that
// restores signs. A new beat is accepted in every cycle unless the receiver
// stalls, so throughput is one beat per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_req.ready drops; nothing is lost or repeated.
// Synchronous reset clears every stage valid bit, so no response is shown
// after reset until new requests arrive.
`default_nettype none

module signed_unsigned_integer_divider_top
    import sud_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sud_stream_if.sink       i_req,
    sud_stream_if.source     o_rsp
);

    localparam int W2 = 2 * WIDTH;

    logic                 w_en;
    logic [WIDTH+FIELD_W-1:0] w_n_ext;
    logic [WIDTH+FIELD_W-1:0] w_d_ext;
    logic [WIDTH-1:0]     w_n;
    logic [WIDTH-1:0]     w_d;
    logic                 w_nneg;
    logic                 w_dneg;

    logic                 r_vld  [0:WIDTH];
    logic [W2-1:0]        r_acc  [0:WIDTH];
    logic [WIDTH-1:0]     r_den  [0:WIDTH];
    logic                 r_qneg [0:WIDTH];
    logic                 r_rneg [0:WIDTH];
    logic                 r_dz   [0:WIDTH];
    logic [W2-1:0]        n_acc  [1:WIDTH];

    logic                 r_out_vld;
    t_rsp                 r_out;
    logic [WIDTH-1:0]     w_q;
    logic [WIDTH-1:0]     w_r;
    logic [WIDTH-1:0]     w_q_fin;
    logic [WIDTH-1:0]     w_r_fin;
    logic [WIDTH+FIELD_W-1:0] w_q_ext;
    logic [WIDTH+FIELD_W-1:0] w_r_ext;

    assign w_en        = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_en;

    assign w_n_ext = {{WIDTH{1'b0}}, i_req.data.dividend};
    assign w_d_ext = {{WIDTH{1'b0}}, i_req.data.divisor};
    assign w_n     = w_n_ext[WIDTH-1:0];
    assign w_d     = w_d_ext[WIDTH-1:0];
    assign w_nneg  = i_req.data.signed_mode && w_n[WIDTH-1];
    assign w_dneg  = i_req.data.signed_mode && w_d[WIDTH-1];

    for (genvar k = 0; k < WIDTH; k++) begin : g_step
        logic [W2-1:0]  w_sh;
        logic [WIDTH:0] w_diff;

        assign w_sh   = {r_acc[k][W2-2:0], 1'b0};
        assign w_diff = {r_acc[k][W2-1], w_sh[W2-1:WIDTH]} - {1'b0, r_den[k]};
        assign n_acc[k+1] = w_diff[WIDTH] ? w_sh
                                          : {w_diff[WIDTH-1:0], w_sh[WIDTH-1:1], 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= WIDTH; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_req.valid;
            for (int s = 1; s <= WIDTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc[0]  <= {{WIDTH{1'b0}}, (w_nneg ? (~w_n + 1'b1) : w_n)};
            r_den[0]  <= w_dneg ? (~w_d + 1'b1) : w_d;
            r_qneg[0] <= w_nneg ^ w_dneg;
            r_rneg[0] <= w_nneg;
            r_dz[0]   <= (w_d == '0);
            for (int s = 1; s <= WIDTH; s++) begin
                r_acc[s]  <= n_acc[s];
                r_den[s]  <= r_den[s-1];
                r_qneg[s] <= r_qneg[s-1];
                r_rneg[s] <= r_rneg[s-1];
                r_dz[s]   <= r_dz[s-1];
            end
        end
    end

    assign w_q     = r_acc[WIDTH][WIDTH-1:0];
    assign w_r     = r_acc[WIDTH][W2-1:WIDTH];
    assign w_q_fin = r_dz[WIDTH] ? '0 : (r_qneg[WIDTH] ? (~w_q + 1'b1) : w_q);
    assign w_r_fin = r_dz[WIDTH] ? '0 : (r_rneg[WIDTH] ? (~w_r + 1'b1) : w_r);
    assign w_q_ext = {{FIELD_W{1'b0}}, w_q_fin};
    assign w_r_ext = {{FIELD_W{1'b0}}, w_r_fin};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.quotient      <= w_q_ext[FIELD_W-1:0];
            r_out.remainder_out <= w_r_ext[FIELD_W-1:0];
            r_out.div_by_zero   <= r_dz[WIDTH];
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/sud_checker.sv =====
// Port checker for the integer divider and its bind to the top level.
`default_nettype none

`include "signed_unsigned_integer_divider_top_macros.svh"

module sud_checker
    import sud_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_req_ready,
    input wire       i_rsp_valid,
    input wire       i_rsp_ready,
    input wire t_rsp i_rsp_data
);

    `SUD_ASSERT(a_stall_hold, i_clk, i_rst_n,
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)),
        "Stalled response beat changed or vanished.")
    `SUD_ASSERT(a_dz_zero, i_clk, i_rst_n,
        (i_rsp_valid && i_rsp_data.div_by_zero)
            |-> (i_rsp_data.quotient == '0 && i_rsp_data.remainder_out == '0),
        "Divide by zero gave nonzero results.")
    `SUD_ASSERT(a_ready_free, i_clk, i_rst_n, !i_rsp_valid |-> i_req_ready,
        "Request stalled while no response waits.")
    `SUD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_rsp_valid,
        "Response valid right after reset.")

endmodule

bind signed_unsigned_integer_divider_top sud_checker u_sud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the signed and unsigned integer divider: queued stimulus, predicted results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sud_pkg::*;

    localparam int DIV_W          = WIDTH_DEF;
    localparam int N_RANDOM       = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = DIV_W + 10;
    localparam int MAX_REPORTS    = 10;
    localparam logic [31:0] READY_PATTERN = 32'b1101_1110_0110_1111_1000_1101_1011_0111;
    localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    logic clk;
    logic rst_n;

    sud_stream_if #(.T(t_req)) req_if ();
    sud_stream_if #(.T(t_rsp)) rsp_if ();

    signed_unsigned_integer_divider_top #(
        .WIDTH(DIV_W)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_req division_queue[$];
    t_rsp quot_rem_queue[$];
    int   n_directed;
    int   issued_count;
    int   burst_left;
    int   gap_left;
    int   ready_phase;
    int   rx_cycles;
    int   idle_cycles;
    int   error_count;
    logic req_fire;

    always #1 clk = ~clk;

    function automatic void restore_divide(input logic [DIV_W-1:0] num,
                                           input logic [DIV_W-1:0] den,
                                           output logic [DIV_W-1:0] quo,
                                           output logic [DIV_W-1:0] rem);
        logic [DIV_W:0] part;
        part = '0;
        quo  = '0;
        for (int k = DIV_W - 1; k >= 0; k--) begin
            part = {part[DIV_W-1:0], num[k]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        rem = part[DIV_W-1:0];
    endfunction

    function automatic t_rsp divide_truncating(t_req item);
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
        logic             num_neg;
        logic             den_neg;
        t_rsp             res;
        num = item.dividend[DIV_W-1:0];
        den = item.divisor[DIV_W-1:0];
        res = '0;
        if (den == '0) begin
            res.div_by_zero = 1'b1;
        end else begin
            num_neg = item.signed_mode & num[DIV_W-1];
            den_neg = item.signed_mode & den[DIV_W-1];
            if (num_neg) num = ~num + 1'b1;
            if (den_neg) den = ~den + 1'b1;
            restore_divide(num, den, quo, rem);
            if (num_neg != den_neg) quo = ~quo + 1'b1;
            if (num_neg) rem = ~rem + 1'b1;
            res.quotient      = quo;
            res.remainder_out = rem;
        end
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = 1;
            2: v = ALL_ONES;
            3: v = MOST_NEG;
            4: v = MOST_POS;
            5: v = $urandom_range(0, 15);
            6: v = -($urandom_range(0, 15));
            7, 8: v = $urandom >> $urandom_range(0, FIELD_W - 1);
            9: v = -($urandom >> $urandom_range(0, FIELD_W - 1));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_division(input logic [FIELD_W-1:0] num,
                                input logic [FIELD_W-1:0] den,
                                input logic sgn);
        t_req item;
        item.dividend    = num;
        item.divisor     = den;
        item.signed_mode = sgn;
        division_queue.push_back(item);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    // Sender: bursts of random length, random gaps, and a full drain at two points.
    always @(negedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if ((issued_count == n_directed || issued_count == n_directed + N_RANDOM / 2)
                    && quot_rem_queue.size() != 0) begin
                req_if.valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (division_queue.size() != 0) begin
                req_if.data  <= division_queue.pop_front();
                req_if.valid <= 1'b1;
                issued_count++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: always ready, a fixed stall pattern, or random stalls, in turn.
    always @(negedge clk) begin
        rx_cycles++;
        ready_phase = (ready_phase + 1) % 31;
        case ((rx_cycles / 256) % 3)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= READY_PATTERN[ready_phase];
            default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Monitor, predictor and watchdog.
    always @(posedge clk) begin
        t_rsp want;
        t_rsp got;
        logic req_beat;
        logic rsp_beat;
        req_beat = rst_n && req_if.valid && req_if.ready;
        rsp_beat = rst_n && rsp_if.valid && rsp_if.ready;
        req_fire <= req_beat;
        if (req_beat) quot_rem_queue.push_back(divide_truncating(req_if.data));
        if (rsp_beat) begin
            got = rsp_if.data;
            if (quot_rem_queue.size() == 0) begin
                flag_error($sformatf("result beat with none expected: q=%h r=%h z=%b",
                                     got.quotient, got.remainder_out, got.div_by_zero));
            end else begin
                want = quot_rem_queue.pop_front();
                if (got.quotient !== want.quotient)
                    flag_error($sformatf("quotient: expected %h, got %h",
                                         want.quotient, got.quotient));
                if (got.remainder_out !== want.remainder_out)
                    flag_error($sformatf("remainder: expected %h, got %h",
                                         want.remainder_out, got.remainder_out));
                if (got.div_by_zero !== want.div_by_zero)
                    flag_error($sformatf("div_by_zero: expected %b, got %b",
                                         want.div_by_zero, got.div_by_zero));
            end
        end
        if (req_beat || rsp_beat) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_unsigned_integer_divider_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        req_fire     = 1'b0;
        issued_count = 0;
        burst_left   = 0;
        gap_left     = 0;
        ready_phase  = 0;
        rx_cycles    = 0;
        idle_cycles  = 0;
        error_count  = 0;

        add_division(0, 1, 1'b0);
        add_division(ALL_ONES, 1, 1'b0);
        add_division(ALL_ONES, ALL_ONES, 1'b0);
        add_division(7, 2, 1'b0);
        add_division(1, ALL_ONES, 1'b0);
        add_division(MOST_NEG, 3, 1'b0);
        add_division(5, 0, 1'b0);
        add_division(0, 0, 1'b0);
        add_division(3, 5, 1'b0);
        add_division(7, -2, 1'b1);
        add_division(-7, 2, 1'b1);
        add_division(-7, -2, 1'b1);
        add_division(7, 2, 1'b1);
        add_division(3, 5, 1'b1);
        add_division(-3, 5, 1'b1);
        add_division(MOST_NEG, ALL_ONES, 1'b1);
        add_division(MOST_NEG, 1, 1'b1);
        add_division(MOST_NEG, 2, 1'b1);
        add_division(MOST_NEG, MOST_NEG, 1'b1);
        add_division(MOST_POS, ALL_ONES, 1'b1);
        add_division(MOST_POS, MOST_POS, 1'b1);
        add_division(ALL_ONES, ALL_ONES, 1'b1);
        add_division(ALL_ONES, 0, 1'b1);
        add_division(MOST_POS, MOST_NEG, 1'b1);
        n_directed = division_queue.size();

        for (int i = 0; i < N_RANDOM; i++)
            add_division(random_operand(), random_operand(), 1'($urandom_range(0, 1)));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (division_queue.size() != 0 || req_if.valid || quot_rem_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && quot_rem_queue.size() == 0) begin
            $display("signed_unsigned_integer_divider_top: match");
        end else begin
            $display("signed_unsigned_integer_divider_top: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sud_pkg.sv
hw/rtl/sud_stream_if.sv
hw/rtl/signed_unsigned_integer_divider_top.sv
hw/rtl/sud_checker.sv
test/tb.sv
